/* src/sphpf_pkg.sv */
// shared types, constants and fixed-point helpers for the sph pressure force block
package sphpf_pkg;

   localparam int Q_SHIFT = 24;
   localparam int MUL_W   = 34;
   localparam int PROD_W  = 2 * MUL_W;

   localparam logic [1:0] CSR_RADIUS = 2'd0;
   localparam logic [1:0] CSR_TARGET = 2'd1;
   localparam logic [1:0] CSR_GAIN   = 2'd2;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   // command from the sequencer to the iterative unit
   typedef struct packed {
      logic start;
      logic is_sqrt;
   } ds_cmd_type;

   // status back from the iterative unit
   typedef struct packed {
      logic        done;
      logic [31:0] result;
   } ds_stat_type;

   // q7.24 product: floor shift by the fraction bits, then clamp to 32 bits
   function automatic logic signed [31:0] qsat(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] sh;
      sh = p >>> Q_SHIFT;
      if (sh > PROD_W'(S32_MAX))
         return S32_MAX;
      else if (sh < PROD_W'(S32_MIN))
         return S32_MIN;
      else
         return sh[31:0];
   endfunction

   // clamp a 49-bit sum to 48 bits signed
   function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
      if (v > 49'sh0_7FFF_FFFF_FFFF)
         return 48'sh7FFF_FFFF_FFFF;
      else if (v < -49'sh0_8000_0000_0000)
         return 48'sh8000_0000_0000;
      else
         return v[47:0];
   endfunction

   // clamp a 48-bit sum to 32 bits signed
   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      if (v > 48'(S32_MAX))
         return S32_MAX;
      else if (v < 48'(S32_MIN))
         return S32_MIN;
      else
         return v[31:0];
   endfunction

endpackage

/* src/sphpf_divsqrt.sv */
// shared iterative unit: restoring square root (2 bits a step) or division (1 bit a step)
module sphpf_divsqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  sphpf_pkg::ds_cmd_type cmd,
   input  logic [63:0]           operand,
   input  logic [30:0]           divisor,
   output sphpf_pkg::ds_stat_type stat
);
   import sphpf_pkg::*;

   logic [63:0] src_ff, src_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] res_ff, res_in;
   logic [30:0] dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        sqrt_ff, sqrt_in;
   logic        done_ff, done_in;
   logic [33:0] sh, trial;
   logic        ge;

   // one step of the shared compare and subtract
   always_comb begin
      sh    = sqrt_ff ? {rem_ff[31:0], src_ff[63:62]} : {rem_ff[32:0], src_ff[63]};
      trial = sqrt_ff ? {res_ff[31:0], 2'b01} : {3'b000, dvs_ff};
      ge    = (sh >= trial);
   end

   // sequencing of the iterations
   always_comb begin
      src_in  = src_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      sqrt_in = sqrt_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         busy_in = 1'b1;
         sqrt_in = cmd.is_sqrt;
         dvs_in  = divisor;
         res_in  = '0;
         if (cmd.is_sqrt) begin
            src_in = {operand[61:0], 2'b00};
            rem_in = '0;
            cnt_in = 5'd30;
         end else begin
            src_in = {operand[31:0], 32'd0};
            rem_in = {2'b00, operand[63:32]};
            cnt_in = 5'd31;
         end
      end else if (busy_ff) begin
         rem_in = ge ? (sh - trial) : sh;
         res_in = {res_ff[30:0], ge};
         src_in = sqrt_ff ? {src_ff[61:0], 2'b00} : {src_ff[62:0], 1'b0};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      src_ff  <= src_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
      sqrt_ff <= sqrt_in;
   end

   assign stat.done   = done_ff;
   assign stat.result = res_ff;

endmodule

/* src/sph_pressure_force_accumulator_core.sv */
// top level: sph pressure force accumulator with shared multiplier and iterative sqrt/divide
// Accumulates the 2D pressure force on one particle over a stream of neighbour beats
// (Q7.24). One beat is taken at a time, and req_tready is low while it is worked on.
// A neighbour inside the radius passes through ten products on one shared multiplier,
// a 31-step square root that runs beside the kernel and pressure multiplies, then two
// 32-step divisions for the x and y components, all on one iterative unit. An empty beat
// goes straight to the finish state. A neighbour outside the radius, or at zero
// distance, goes to the finish state after the range check. A beat with tlast high adds
// the output state and produces one result beat with the saturated force, then clears
// the sum. The next beat is taken while that result waits, unless it too ends a
// particle; then it waits until the earlier result is read.
module sph_pressure_force_accumulator_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // self_x, self_y, neighbour_x, neighbour_y, neighbour_density, neighbour_volume
   input  logic [191:0] req_tdata,
   // has_neighbour
   input  logic         req_tuser,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // force_x, force_y
   output logic [63:0]  rsp_tdata,
   input  logic         csr_wen,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);
   import sphpf_pkg::*;

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_MR2  = 5'd1;
   localparam logic [4:0] S_MX2  = 5'd2;
   localparam logic [4:0] S_MY2  = 5'd3;
   localparam logic [4:0] S_CHK  = 5'd4;
   localparam logic [4:0] S_MK2  = 5'd5;
   localparam logic [4:0] S_K2   = 5'd6;
   localparam logic [4:0] S_MK3  = 5'd7;
   localparam logic [4:0] S_K3   = 5'd8;
   localparam logic [4:0] S_MP   = 5'd9;
   localparam logic [4:0] S_P    = 5'd10;
   localparam logic [4:0] S_MV   = 5'd11;
   localparam logic [4:0] S_V    = 5'd12;
   localparam logic [4:0] S_MS   = 5'd13;
   localparam logic [4:0] S_S    = 5'd14;
   localparam logic [4:0] S_WSQ  = 5'd15;
   localparam logic [4:0] S_MDX  = 5'd16;
   localparam logic [4:0] S_DX   = 5'd17;
   localparam logic [4:0] S_WDX  = 5'd18;
   localparam logic [4:0] S_MDY  = 5'd19;
   localparam logic [4:0] S_DY   = 5'd20;
   localparam logic [4:0] S_WDY  = 5'd21;
   localparam logic [4:0] S_FIN  = 5'd22;
   localparam logic [4:0] S_OUT  = 5'd23;

   logic [4:0]          state_ff, state_in;
   logic [30:0]         radius_ff;
   logic signed [31:0]  target_ff, gain_ff;
   logic signed [32:0]  dx_ff, dy_ff;
   logic signed [31:0]  dens_ff, vol_ff;
   logic                last_ff;
   logic [61:0]         r2_ff;
   logic [63:0]         ax2_ff;
   logic [30:0]         k_ff;
   logic signed [31:0]  t_ff, k3_ff, s_ff;
   logic [30:0]         d_ff;
   logic                neg_ff;
   logic signed [47:0]  sum_x_ff, sum_y_ff;
   logic                rsp_valid_ff;
   logic [63:0]         rsp_data_ff;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_abs;
   logic [63:0]         ay2, d2;
   logic [61:0]         kdiff;
   logic [37:0]         kraw;
   logic signed [31:0]  pq;
   logic signed [32:0]  quot;
   logic signed [32:0]  pdiff;
   logic                skip;
   ds_cmd_type          ds_cmd;
   ds_stat_type         ds_stat;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // operand selection for the shared multiplier
   always_comb begin
      pdiff = 33'(dens_ff) - 33'(target_ff);
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_MR2: begin
            mul_a = {3'b000, radius_ff};
            mul_b = {3'b000, radius_ff};
         end
         S_MX2: begin
            mul_a = MUL_W'(dx_ff);
            mul_b = MUL_W'(dx_ff);
         end
         S_MY2: begin
            mul_a = MUL_W'(dy_ff);
            mul_b = MUL_W'(dy_ff);
         end
         S_MK2: begin
            mul_a = {3'b000, k_ff};
            mul_b = {3'b000, k_ff};
         end
         S_MK3: begin
            mul_a = MUL_W'(t_ff);
            mul_b = {3'b000, k_ff};
         end
         S_MP: begin
            mul_a = MUL_W'(pdiff);
            mul_b = MUL_W'(gain_ff);
         end
         S_MV: begin
            mul_a = MUL_W'(t_ff);
            mul_b = MUL_W'(vol_ff);
         end
         S_MS: begin
            mul_a = MUL_W'(t_ff);
            mul_b = MUL_W'(k3_ff);
         end
         S_MDX: begin
            mul_a = MUL_W'(dx_ff);
            mul_b = MUL_W'(s_ff);
         end
         S_MDY: begin
            mul_a = MUL_W'(dy_ff);
            mul_b = MUL_W'(s_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // range check, kernel base and signed quotient
   always_comb begin
      ay2      = prod_ff[63:0];
      d2       = ax2_ff + ay2;
      skip     = (ax2_ff >= {2'b00, r2_ff}) || (ay2 >= ({2'b00, r2_ff} - ax2_ff));
      kdiff    = r2_ff - d2[61:0];
      kraw     = kdiff[61:Q_SHIFT];
      pq       = qsat(prod_ff);
      prod_abs = prod_ff[PROD_W-1] ? -prod_ff : prod_ff;
      quot     = neg_ff ? -{1'b0, ds_stat.result} : {1'b0, ds_stat.result};
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      ds_cmd.start   = 1'b0;
      ds_cmd.is_sqrt = 1'b0;
      unique case (state_ff)
         S_IDLE: if (req_tvalid) state_in = req_tuser ? S_MR2 : S_FIN;
         S_MR2:  state_in = S_MX2;
         S_MX2:  state_in = S_MY2;
         S_MY2:  state_in = S_CHK;
         S_CHK: begin
            if (skip || d2 == 64'd0) begin
               state_in = S_FIN;
            end else begin
               state_in       = S_MK2;
               ds_cmd.start   = 1'b1;
               ds_cmd.is_sqrt = 1'b1;
            end
         end
         S_MK2:  state_in = S_K2;
         S_K2:   state_in = S_MK3;
         S_MK3:  state_in = S_K3;
         S_K3:   state_in = S_MP;
         S_MP:   state_in = S_P;
         S_P:    state_in = S_MV;
         S_MV:   state_in = S_V;
         S_V:    state_in = S_MS;
         S_MS:   state_in = S_S;
         S_S:    state_in = S_WSQ;
         S_WSQ:  if (ds_stat.done) state_in = S_MDX;
         S_MDX:  state_in = S_DX;
         S_DX: begin
            state_in     = S_WDX;
            ds_cmd.start = 1'b1;
         end
         S_WDX:  if (ds_stat.done) state_in = S_MDY;
         S_MDY:  state_in = S_DY;
         S_DY: begin
            state_in     = S_WDY;
            ds_cmd.start = 1'b1;
         end
         S_WDY:  if (ds_stat.done) state_in = S_FIN;
         S_FIN:  state_in = last_ff ? S_OUT : S_IDLE;
         S_OUT:  if (!rsp_valid_ff || rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   sphpf_divsqrt u_divsqrt (
      .clock   (clock),
      .reset   (reset),
      .cmd     (ds_cmd),
      .operand (state_ff == S_CHK ? d2 : prod_abs[63:0]),
      .divisor (d_ff),
      .stat    (ds_stat)
   );

   // control state, configuration and sums
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         radius_ff    <= 31'h0100_0000;
         target_ff    <= 32'sd1678;
         gain_ff      <= 32'sd1678;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wen) begin
            case (csr_index)
               CSR_RADIUS: radius_ff <= csr_wdata[30:0];
               CSR_TARGET: target_ff <= csr_wdata;
               CSR_GAIN:   gain_ff   <= csr_wdata;
               default:    ;
            endcase
         end
         if (state_ff == S_WDX && ds_stat.done)
            sum_x_ff <= sat48(49'(sum_x_ff) + 49'(quot));
         if (state_ff == S_WDY && ds_stat.done)
            sum_y_ff <= sat48(49'(sum_y_ff) + 49'(quot));
         // load a new result beat, or drop the one just taken
         if (state_ff == S_OUT && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
            sum_x_ff     <= '0;
            sum_y_ff     <= '0;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (state_ff == S_IDLE && req_tvalid) begin
         dx_ff   <= 33'(signed'(req_tdata[31:0]))  - 33'(signed'(req_tdata[95:64]));
         dy_ff   <= 33'(signed'(req_tdata[63:32])) - 33'(signed'(req_tdata[127:96]));
         dens_ff <= req_tdata[159:128];
         vol_ff  <= req_tdata[191:160];
         last_ff <= req_tlast;
      end
      if (state_ff == S_MX2) r2_ff  <= prod_ff[61:0];
      if (state_ff == S_MY2) ax2_ff <= prod_ff[63:0];
      if (state_ff == S_CHK) k_ff   <= (kraw > 38'h00_7FFF_FFFF) ? 31'h7FFF_FFFF : kraw[30:0];
      if (state_ff == S_K2 || state_ff == S_P || state_ff == S_V) t_ff <= pq;
      if (state_ff == S_K3) k3_ff <= pq;
      if (state_ff == S_S)  s_ff  <= (pq == S32_MIN) ? S32_MAX : -pq;
      if (state_ff == S_WSQ && ds_stat.done) d_ff <= ds_stat.result[30:0];
      if (state_ff == S_DX || state_ff == S_DY) neg_ff <= prod_ff[PROD_W-1];
      if (state_ff == S_OUT && (!rsp_valid_ff || rsp_tready))
         rsp_data_ff <= {sat32(sum_y_ff), sat32(sum_x_ff)};
   end

endmodule

/* src/sphpf_checker.sv */
// port-level checks for the sph pressure force accumulator, bound to the top level
module sphpf_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [63:0]  rsp_tdata
);
   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // one beat at a time: busy right after an accepted beat
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while busy");

   // no result right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a result never appears in the cycle after a beat is taken
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result too early");

endmodule

bind sph_pressure_force_accumulator_core sphpf_checker u_sphpf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
